### rtl/core/key_debounce_hold_event_queue_assert.svh
// Assertion shorthands used by the checker file.
`ifndef KEY_DEBOUNCE_HOLD_EVENT_QUEUE_ASSERT_SVH
`define KEY_DEBOUNCE_HOLD_EVENT_QUEUE_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define KDHQ_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define KDHQ_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/kdhq_pkg.sv
`default_nettype none

package kdhq_pkg;

   localparam int KEYS        = 2;
   localparam int QUEUE_DEPTH = 16;

   localparam int KEY_IDX_W  = (KEYS > 1) ? $clog2(KEYS) : 1;
   localparam int PTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int EV_PER_KEY = 2;
   localparam int SLOTS      = EV_PER_KEY * KEYS;

   localparam int CODE_W   = 4;
   localparam int LEVEL_W  = 4;
   localparam int QCOUNT_W = 5;
   localparam int DB_W     = 8;
   localparam int HOLD_W   = 16;
   localparam int DATA_W   = 32;
   localparam int ADDR_W   = 5;
   localparam int NUM_HOLD = 4;
   localparam int IDX_W    = 3;

   localparam logic REQ_SCAN = 1'b0;
   localparam logic REQ_POP  = 1'b1;

   localparam logic [1:0] EV_PRESS   = 2'd1;
   localparam logic [1:0] EV_HOLD    = 2'd2;
   localparam logic [1:0] EV_RELEASE = 2'd3;

   localparam logic [CODE_W-1:0] CODE_NONE = '0;

   localparam logic [IDX_W-1:0] REG_DEBOUNCE = 3'd0;
   localparam logic [IDX_W-1:0] REG_PRESS    = 3'd1;
   localparam logic [IDX_W-1:0] REG_HOLD0    = 3'd2;
   localparam logic [IDX_W-1:0] REG_HOLD1    = 3'd3;
   localparam logic [IDX_W-1:0] REG_HOLD2    = 3'd4;
   localparam logic [IDX_W-1:0] REG_HOLD3    = 3'd5;

   localparam logic [DB_W-1:0]   DEBOUNCE_RESET = 8'd5;
   localparam logic [HOLD_W-1:0] PRESS_RESET    = 16'd5;
   localparam logic [HOLD_W-1:0] HOLD_RESET [NUM_HOLD] = '{16'd50, 16'd100, 16'd0, 16'd0};

   typedef struct packed {
      logic              vld;
      logic [CODE_W-1:0] code;
   } event_type;

   typedef struct packed {
      logic [DB_W-1:0]   debounce_ticks;
      logic [HOLD_W-1:0] press_ticks;
   } timing_type;

   typedef struct packed {
      logic [CODE_W-1:0]   code;
      logic [QCOUNT_W-1:0] count;
      logic                overflow;
   } result_type;

   // Event numbering: 3*key + kind.
   function automatic logic [CODE_W-1:0] event_code_f(input logic [KEY_IDX_W-1:0] id,
                                                      input logic [1:0] kind);
      return CODE_W'(3 * int'(id) + int'(kind));
   endfunction

endpackage

`default_nettype wire

### rtl/core/kdhq_lane.sv
`default_nettype none

module kdhq_lane import kdhq_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    scan_en,
   input  wire logic                    pressed,
   input  wire logic [KEY_IDX_W-1:0]    key_id,
   input  wire timing_type              timing,
   input  wire logic [HOLD_W-1:0]       hold_limit,
   output event_type [EV_PER_KEY-1:0]   events
);

   logic [DB_W-1:0]   debounce_ff, debounce_in;
   logic [HOLD_W-1:0] hold_ff, hold_in;
   logic              reported_ff, reported_in;
   logic [HOLD_W-1:0] hold_inc;
   logic [DB_W-1:0]   clamped;
   logic [DB_W-1:0]   lowered;

   always_comb begin
      debounce_in = debounce_ff;
      hold_in     = hold_ff;
      reported_in = reported_ff;
      hold_inc    = hold_ff + 1'b1;
      clamped     = (debounce_ff > timing.debounce_ticks) ? timing.debounce_ticks
                                                          : debounce_ff;
      lowered     = (clamped != '0) ? clamped - 1'b1 : clamped;

      events[0].vld  = 1'b0;
      events[0].code = event_code_f(key_id, pressed ? EV_PRESS : EV_RELEASE);
      events[1].vld  = 1'b0;
      events[1].code = event_code_f(key_id, EV_HOLD);

      if (pressed) begin
         if (debounce_ff < timing.debounce_ticks) begin
            debounce_in = debounce_ff + 1'b1;
         end else if (hold_limit != '0) begin
            if (hold_ff < hold_limit) begin
               hold_in       = hold_inc;
               events[0].vld = (hold_inc == timing.press_ticks);
               events[1].vld = (hold_inc >= hold_limit);
            end
         end else if (!reported_ff) begin
            // zero hold limit: one press event per debounced press
            reported_in   = 1'b1;
            events[0].vld = 1'b1;
         end
      end else begin
         if (debounce_ff != '0) begin
            debounce_in   = lowered;
            events[0].vld = (lowered == '0);
         end
         hold_in     = '0;
         reported_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= '0;
         hold_ff     <= '0;
         reported_ff <= 1'b0;
      end else if (scan_en) begin
         debounce_ff <= debounce_in;
         hold_ff     <= hold_in;
         reported_ff <= reported_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/kdhq_queue.sv
`default_nettype none

module kdhq_queue import kdhq_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  scan_en,
   input  wire logic                  pop_en,
   input  wire event_type [SLOTS-1:0] slots,
   output result_type                 result
);

   logic [CODE_W-1:0] store_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              overflow_ff, overflow_in;
   logic [SLOTS-1:0]  wr_en;
   logic [PTR_W-1:0]  wr_addr [SLOTS];
   logic [CODE_W-1:0] pop_code;

   function automatic logic [PTR_W-1:0] ptr_next_f(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   // Merge: lane events in key order, press before hold; each push sees
   // the fill level left by the ones ahead of it.
   always_comb begin
      rd_ptr_in   = rd_ptr_ff;
      wr_ptr_in   = wr_ptr_ff;
      count_in    = count_ff;
      overflow_in = overflow_ff;
      pop_code    = CODE_NONE;
      for (int s = 0; s < SLOTS; s++) begin
         wr_en[s]   = 1'b0;
         wr_addr[s] = wr_ptr_in;
         if (scan_en && slots[s].vld) begin
            if (count_in < CNT_W'(QUEUE_DEPTH)) begin
               wr_en[s]  = 1'b1;
               wr_ptr_in = ptr_next_f(wr_ptr_in);
               count_in  = count_in + 1'b1;
            end else begin
               overflow_in = 1'b1;
            end
         end
      end
      if (pop_en && count_ff != '0) begin
         pop_code  = store_ff[rd_ptr_ff];
         rd_ptr_in = ptr_next_f(rd_ptr_ff);
         count_in  = count_ff - 1'b1;
      end
      result.code     = pop_code;
      result.count    = QCOUNT_W'(count_in);
      result.overflow = overflow_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff   <= '0;
         wr_ptr_ff   <= '0;
         count_ff    <= '0;
         overflow_ff <= 1'b0;
      end else begin
         rd_ptr_ff   <= rd_ptr_in;
         wr_ptr_ff   <= wr_ptr_in;
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < SLOTS; s++) begin
         if (wr_en[s]) begin
            store_ff[wr_addr[s]] <= slots[s].code;
         end
      end
   end

endmodule

`default_nettype wire

### rtl/core/key_debounce_hold_event_queue.sv
// Key debounce with press/hold/release events in a 16-entry queue. Takes one
// item per clock while req_stall is low: a scan tick (req_type 0) runs every
// key's debounce and hold counters in parallel and pushes their events in key
// order, a pop (req_type 1) takes the oldest event. Results go to the rsp_
// channel through an output register plus one skid register, which let the
// input take one more item after rsp_stall rises, so req_stall is simply the
// skid register being full. The user must write registers over the APB port
// only while no item is in flight; the block itself does not enforce this.
`default_nettype none

module key_debounce_hold_event_queue import kdhq_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic                req_type,
   input  wire logic [LEVEL_W-1:0]  req_key_levels,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [CODE_W-1:0]        rsp_event_code,
   output logic [QCOUNT_W-1:0]      rsp_queue_count,
   output logic                     rsp_overflow,
   input  wire logic                psel,
   input  wire logic                penable,
   input  wire logic                pwrite,
   input  wire logic [ADDR_W-1:0]   paddr,
   input  wire logic [DATA_W-1:0]   pwdata,
   output logic [DATA_W-1:0]        prdata,
   output logic                     pready
);

   logic [DB_W-1:0]   debounce_ff, debounce_in;
   logic [HOLD_W-1:0] press_ff, press_in;
   logic [HOLD_W-1:0] hold_ff [NUM_HOLD];
   logic [HOLD_W-1:0] hold_in [NUM_HOLD];
   logic [IDX_W-1:0]  reg_idx;
   logic              csr_write;
   timing_type        timing;

   logic              in_fire, out_fire, scan_en, pop_en;
   event_type [SLOTS-1:0] slots;
   result_type        result;
   result_type        out_ff, out_in, skid_ff, skid_in;
   logic              out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;

   // configuration
   assign pready    = 1'b1;
   assign reg_idx   = paddr[ADDR_W-1:2];
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      debounce_in = debounce_ff;
      press_in    = press_ff;
      hold_in     = hold_ff;
      if (csr_write) begin
         case (reg_idx)
            REG_DEBOUNCE: debounce_in = pwdata[DB_W-1:0];
            REG_PRESS:    press_in    = pwdata[HOLD_W-1:0];
            REG_HOLD0:    hold_in[0]  = pwdata[HOLD_W-1:0];
            REG_HOLD1:    hold_in[1]  = pwdata[HOLD_W-1:0];
            REG_HOLD2:    hold_in[2]  = pwdata[HOLD_W-1:0];
            REG_HOLD3:    hold_in[3]  = pwdata[HOLD_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_DEBOUNCE: prdata = DATA_W'(debounce_ff);
         REG_PRESS:    prdata = DATA_W'(press_ff);
         REG_HOLD0:    prdata = DATA_W'(hold_ff[0]);
         REG_HOLD1:    prdata = DATA_W'(hold_ff[1]);
         REG_HOLD2:    prdata = DATA_W'(hold_ff[2]);
         REG_HOLD3:    prdata = DATA_W'(hold_ff[3]);
         default:      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RESET;
         press_ff    <= PRESS_RESET;
         hold_ff     <= HOLD_RESET;
      end else begin
         debounce_ff <= debounce_in;
         press_ff    <= press_in;
         hold_ff     <= hold_in;
      end
   end

   assign timing.debounce_ticks = debounce_ff;
   assign timing.press_ticks    = press_ff;

   // handshake
   assign req_stall = skid_valid_ff;
   assign in_fire   = req_valid && !skid_valid_ff;
   assign out_fire  = out_valid_ff && !rsp_stall;
   assign scan_en   = in_fire && (req_type == REQ_SCAN);
   assign pop_en    = in_fire && (req_type == REQ_POP);

   // one lane per key
   for (genvar k = 0; k < KEYS; k++) begin : g_lane
      kdhq_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .scan_en    (scan_en),
         .pressed    (!req_key_levels[k]),
         .key_id     (KEY_IDX_W'(k)),
         .timing     (timing),
         .hold_limit (hold_ff[k]),
         .events     (slots[EV_PER_KEY*k +: EV_PER_KEY])
      );
   end

   kdhq_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .scan_en (scan_en),
      .pop_en  (pop_en),
      .slots   (slots),
      .result  (result)
   );

   // output register and skid
   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || out_fire) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = result;
            out_valid_in = in_fire;
         end
      end else if (in_fire) begin
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_event_code  = out_ff.code;
   assign rsp_queue_count = out_ff.count;
   assign rsp_overflow    = out_ff.overflow;

endmodule

`default_nettype wire

### rtl/core/kdhq_checker.sv
`default_nettype none

`include "key_debounce_hold_event_queue_assert.svh"

module kdhq_checker import kdhq_pkg::*; (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_stall,
   input wire logic                rsp_valid,
   input wire logic                rsp_stall,
   input wire logic [CODE_W-1:0]   rsp_event_code,
   input wire logic [QCOUNT_W-1:0] rsp_queue_count,
   input wire logic                rsp_overflow
);

   logic seen_overflow_ff, seen_overflow_in;
   logic req_transfer;

   assign req_transfer     = req_valid && !req_stall;
   assign seen_overflow_in = seen_overflow_ff || (rsp_valid && !rsp_stall && rsp_overflow);

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_overflow_ff <= 1'b0;
      end else begin
         seen_overflow_ff <= seen_overflow_in;
      end
   end

   `KDHQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_event_code) && $stable(rsp_queue_count) && $stable(rsp_overflow), "stalled result changed")

   `KDHQ_ASSERT_NOW(a_overflow_sticky, rsp_valid && seen_overflow_ff, rsp_overflow, "overflow flag cleared")

   `KDHQ_ASSERT_NOW(a_count_range, rsp_valid, (QUEUE_DEPTH > 31) || (rsp_queue_count <= QCOUNT_W'(QUEUE_DEPTH)), "queue count above depth")

   `KDHQ_ASSERT_NOW(a_code_range, rsp_valid, rsp_event_code <= CODE_W'(3 * KEYS), "event code beyond last key")

   `KDHQ_ASSERT_NEXT(a_result_follows, req_transfer && !rsp_valid, rsp_valid, "no result after transfer")

endmodule

bind key_debounce_hold_event_queue kdhq_checker u_kdhq_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_event_code  (rsp_event_code),
   .rsp_queue_count (rsp_queue_count),
   .rsp_overflow    (rsp_overflow)
);

`default_nettype wire
